// File: design/tmn_pkg.sv
`timescale 1ns / 1ps

package tmn_pkg;

   localparam int MAX_MOTORS  = 6;
   localparam int MOTOR_W     = $clog2(MAX_MOTORS + 1);
   localparam int CSR_IDX_W   = 3;
   localparam int WORD_W      = 56;
   localparam int POWER_W     = 34;
   localparam int QUO_W       = 15;
   localparam int DIV_STEPS   = 15;
   localparam int STEP_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_WORD0 = 3'd1;

   localparam logic [1:0] AXIS_FWD  = 2'd0;
   localparam logic [1:0] AXIS_SIDE = 2'd1;
   localparam logic [1:0] AXIS_TURN = 2'd2;

   localparam logic [POWER_W-1:0] ONE_Q27 = 34'd1 << 27;

   typedef struct packed {
      logic [1:0]         axis;
      logic signed [15:0] velocity;
   } req_type;

   typedef struct packed {
      logic [7:0]         channel;
      logic signed [15:0] duty;
      logic               last;
   } rsp_type;

endpackage

// File: design/thruster_mix_normalizer.sv
`timescale 1ns / 1ps

// Thruster mixer: each request transaction with axis 0 to 2 sets one of three velocity targets
// (forward, sideways, turn, Q1.14), then every configured motor gets the sum
// of target times coefficient (Q2.13) and, when the largest magnitude exceeds
// 1.0, all levels are scaled by it. One response transaction per motor
// follows in motor order, with last on the final one. A single 16x16
// multiplier serves every motor in turn; each duty then comes straight from
// the level without scaling or through the shared restoring divider when
// scaling; each response waits out rsp_stall. req_stall is high for the
// whole item. Registers are written through the csr_ port, which is always
// ready; index 0 is the motor count, 1 to 6 the motor words, others are
// ignored.
module thruster_mix_normalizer
   import tmn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [MOTOR_W-1:0]        motor_ff, motor_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [2:0]                count_ff;
   logic [WORD_W-1:0]         word_ff [MAX_MOTORS];
   logic signed [15:0]        fwd_ff, side_ff, turn_ff;
   logic signed [31:0]        prod_ff, prod_in;
   logic signed [POWER_W-1:0] acc_ff, acc_in;
   logic signed [POWER_W-1:0] power_ff [MAX_MOTORS];
   logic [POWER_W-1:0]        peak_ff, peak_in;
   logic [POWER_W:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [MOTOR_W-1:0]        count_eff;
   logic [MOTOR_W-1:0]        last_motor;
   logic                      req_accept;
   logic [WORD_W-1:0]         word_sel;
   logic signed [15:0]        mul_a, mul_b;
   logic signed [POWER_W-1:0] power_sum;
   logic [POWER_W-1:0]        power_mag;
   logic signed [POWER_W-1:0] power_sel;
   logic [POWER_W-1:0]        sel_mag;
   logic [POWER_W:0]          trial;
   logic                      trial_ge;
   logic                      scale;
   logic                      rsp_load;
   logic [QUO_W-1:0]          quo_final;
   logic [CSR_IDX_W-1:0]      word_idx;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign count_eff  = (count_ff > MAX_MOTORS[2:0]) ? MOTOR_W'(MAX_MOTORS)
                                                     : MOTOR_W'(count_ff);
   assign last_motor = count_eff - MOTOR_W'(1);
   assign word_sel   = word_ff[motor_ff];
   assign word_idx   = csr_index - CSR_MOTOR_WORD0;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin
            mul_a = fwd_ff;
            mul_b = word_sel[15:0];
         end
         2'd1: begin
            mul_a = side_ff;
            mul_b = word_sel[31:16];
         end
         default: begin
            mul_a = turn_ff;
            mul_b = word_sel[47:32];
         end
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign power_sum = acc_ff + POWER_W'(prod_ff);
   assign power_mag = power_sum[POWER_W-1] ? POWER_W'(-power_sum) : POWER_W'(power_sum);
   assign power_sel = power_ff[motor_ff];
   assign sel_mag   = power_sel[POWER_W-1] ? POWER_W'(-power_sel) : POWER_W'(power_sel);
   assign scale     = (peak_ff > ONE_Q27);
   assign trial     = (step_ff == STEP_W'(1)) ? rem_ff : {rem_ff[POWER_W-1:0], 1'b0};
   assign trial_ge  = (trial >= {1'b0, peak_ff});

   always_comb begin
      state_in     = state_ff;
      motor_in     = motor_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      peak_in      = peak_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      quo_final    = quo_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               peak_in  = '0;
               motor_in = '0;
               step_in  = '0;
               if (count_eff != '0) begin
                  state_in = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               acc_in = POWER_W'(prod_ff);
            end else if (step_ff == STEP_W'(2)) begin
               acc_in = power_sum;
            end else if (step_ff == STEP_W'(3)) begin
               if (power_mag > peak_ff) begin
                  peak_in = power_mag;
               end
               step_in = '0;
               if (motor_ff == last_motor) begin
                  motor_in = '0;
                  state_in = ST_DIV;
               end else begin
                  motor_in = motor_ff + MOTOR_W'(1);
               end
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == '0) begin
               neg_in = power_sel[POWER_W-1];
               rem_in = {1'b0, sel_mag};
               quo_in = '0;
               if (!scale) begin
                  quo_final = sel_mag[27:13];
                  rsp_load  = 1'b1;
               end
            end else begin
               rem_in = trial_ge ? (trial - {1'b0, peak_ff}) : trial;
               quo_in = {quo_ff[QUO_W-2:0], trial_ge};
               if (step_ff == STEP_W'(DIV_STEPS)) begin
                  quo_final = quo_in;
                  rsp_load  = 1'b1;
               end
            end
            if (rsp_load) begin
               state_in     = ST_SEND;
               rsp_valid_in = 1'b1;
               step_in      = '0;
            end
         end
         default: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (motor_ff == last_motor) begin
                  state_in = ST_IDLE;
               end else begin
                  motor_in = motor_ff + MOTOR_W'(1);
                  state_in = ST_DIV;
               end
            end
         end
      endcase

      rsp_in.channel = word_sel[55:48];
      rsp_in.last    = (motor_ff == last_motor);
      rsp_in.duty    = (state_ff == ST_DIV && step_ff == '0) ?
                          (power_sel[POWER_W-1] ? -$signed({1'b0, quo_final})
                                                :  $signed({1'b0, quo_final})) :
                          (neg_ff ? -$signed({1'b0, quo_final})
                                  :  $signed({1'b0, quo_final}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         fwd_ff       <= '0;
         side_ff      <= '0;
         turn_ff      <= '0;
         peak_ff      <= '0;
         for (int i = 0; i < MAX_MOTORS; i++) begin
            word_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MOTOR_COUNT) begin
               count_ff <= csr_wdata[2:0];
            end else if (csr_index <= CSR_IDX_W'(MAX_MOTORS)) begin
               word_ff[word_idx] <= csr_wdata;
            end
         end
         if (req_accept) begin
            unique case (req_data.axis)
               AXIS_FWD:  fwd_ff  <= req_data.velocity;
               AXIS_SIDE: side_ff <= req_data.velocity;
               AXIS_TURN: turn_ff <= req_data.velocity;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      if (state_ff == ST_MIX && step_ff == STEP_W'(3)) begin
         power_ff[motor_ff] <= power_sum;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: tb/sv/thruster_mix_normalizer_tb.sv
`timescale 1ns / 1ps

module thruster_mix_normalizer_tb;
   import tmn_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 140;
   localparam int HOLD_CYCLES   = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // mirror of the block's registers and targets
   logic [2:0]         motor_count;
   logic [WORD_W-1:0]  motor_word [MAX_MOTORS];
   logic signed [15:0] fwd_target;
   logic signed [15:0] side_target;
   logic signed [15:0] turn_target;

   rsp_type pending_duties [$];
   int      mismatch_count = 0;
   bit      req_gaps_on = 1'b0;
   bit      rsp_stalls_on = 1'b0;
   bit      hold_request = 1'b0;
   int      hold_left = 0;
   int      stall_left = 0;

   thruster_mix_normalizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_coef();
      int r;
      int v;
      r = $urandom_range(0, 9);
      v = $urandom_range(0, 2048) - 1024;
      case (r)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3, 4, 5: return v[15:0];
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_motor_word();
      logic [7:0] channel;
      channel = 8'($urandom);
      return {channel, random_coef(), random_coef(), random_coef()};
   endfunction

   function automatic logic [15:0] random_velocity();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic mix_and_normalize(input req_type item);
      longint  power [MAX_MOTORS];
      longint  peak;
      longint  mag;
      longint  q;
      int      count;
      rsp_type r;
      case (item.axis)
         AXIS_FWD:  fwd_target = item.velocity;
         AXIS_SIDE: side_target = item.velocity;
         AXIS_TURN: turn_target = item.velocity;
         default: ;
      endcase
      count = (int'(motor_count) > MAX_MOTORS) ? MAX_MOTORS : int'(motor_count);
      peak = 0;
      for (int i = 0; i < count; i++) begin
         power[i] = longint'(fwd_target) * longint'($signed(motor_word[i][15:0]))
                  + longint'(side_target) * longint'($signed(motor_word[i][31:16]))
                  + longint'(turn_target) * longint'($signed(motor_word[i][47:32]));
         mag = (power[i] < 0) ? -power[i] : power[i];
         if (mag > peak) peak = mag;
      end
      for (int i = 0; i < count; i++) begin
         mag = (power[i] < 0) ? -power[i] : power[i];
         if (peak > longint'(ONE_Q27)) q = (mag * 16384) / peak;
         else q = mag / 8192;
         if (power[i] < 0) q = -q;
         r.channel = motor_word[i][55:48];
         r.duty = q[15:0];
         r.last = (i == count - 1);
         pending_duties.push_back(r);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_MOTOR_COUNT) begin
         motor_count = data[2:0];
      end else if (int'(index) >= int'(CSR_MOTOR_WORD0)
                   && int'(index) < int'(CSR_MOTOR_WORD0) + MAX_MOTORS) begin
         motor_word[int'(index) - int'(CSR_MOTOR_WORD0)] = data;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_velocity(input logic [1:0] axis, input logic [15:0] velocity);
      req_type item;
      int      gap;
      item.axis = axis;
      item.velocity = velocity;
      gap = req_gaps_on ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      mix_and_normalize(item);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_motors(input logic [2:0] count);
      write_register(CSR_MOTOR_COUNT, WORD_W'(count));
      for (int i = 0; i < MAX_MOTORS; i++)
         write_register(CSR_MOTOR_WORD0 + 3'(i), random_motor_word());
   endtask

   // responses
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duties.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: channel %0d duty %0d last %0b",
                        rsp_data.channel, rsp_data.duty, rsp_data.last);
         end else begin
            want = pending_duties.pop_front();
            if (rsp_data.channel !== want.channel || rsp_data.duty !== want.duty
                || rsp_data.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected ch %0d duty %0d last %0b, got ch %0d duty %0d last %0b",
                           want.channel, want.duty, want.last,
                           rsp_data.channel, rsp_data.duty, rsp_data.last);
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!rsp_stalls_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0) stall_left = gap_length();
      end
   end

   task automatic test_no_motors();
      motor_count = '0;
      fwd_target = '0;
      side_target = '0;
      turn_target = '0;
      for (int i = 0; i < MAX_MOTORS; i++) motor_word[i] = '0;
      send_velocity(AXIS_FWD, 16'h4000);
      send_velocity(AXIS_TURN, 16'h8000);
      settle_block();
   endtask

   task automatic test_unity_boundary();
      write_register(CSR_MOTOR_COUNT, WORD_W'(2));
      write_register(CSR_MOTOR_WORD0, {8'h00, 16'h0000, 16'h0000, 16'h2000});
      write_register(CSR_MOTOR_WORD0 + 3'd1, {8'hFF, 16'h0000, 16'h0000, 16'hE000});
      send_velocity(AXIS_FWD, 16'h4000);
      send_velocity(AXIS_FWD, 16'h4001);
      send_velocity(AXIS_FWD, 16'hC000);
      send_velocity(AXIS_FWD, 16'h8000);
      send_velocity(AXIS_FWD, 16'h7FFF);
      send_velocity(AXIS_FWD, 16'h0001);
      send_velocity(AXIS_FWD, 16'hFFFF);
      settle_block();
   endtask

   task automatic test_extreme_coefs();
      write_register(CSR_MOTOR_COUNT, WORD_W'(6));
      write_register(CSR_MOTOR_WORD0, {8'h00, 16'h0000, 16'h0000, 16'h2000});
      write_register(CSR_MOTOR_WORD0 + 3'd1, {8'hFF, 16'h0000, 16'h0000, 16'hE000});
      write_register(CSR_MOTOR_WORD0 + 3'd2, {8'hA5, 16'h0000, 16'h7FFF, 16'h0000});
      write_register(CSR_MOTOR_WORD0 + 3'd3, {8'h5A, 16'h8000, 16'h0000, 16'h0000});
      write_register(CSR_MOTOR_WORD0 + 3'd4, {8'h01, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      write_register(CSR_MOTOR_WORD0 + 3'd5, {8'h80, 16'h8000, 16'h8000, 16'h8000});
      send_velocity(AXIS_FWD, 16'h7FFF);
      send_velocity(AXIS_SIDE, 16'h8000);
      send_velocity(AXIS_TURN, 16'h7FFF);
      send_velocity(2'd3, 16'h1234);
      send_velocity(AXIS_TURN, 16'h0000);
      send_velocity(AXIS_SIDE, 16'h0000);
      send_velocity(AXIS_FWD, 16'h0000);
      send_velocity(AXIS_FWD, 16'h8000);
      send_velocity(AXIS_SIDE, 16'h8000);
      send_velocity(AXIS_TURN, 16'h8000);
      settle_block();
      // count beyond the motor limit clamps; unused index is ignored
      write_register(CSR_MOTOR_COUNT, WORD_W'(7));
      send_velocity(AXIS_SIDE, 16'h2000);
      send_velocity(2'd3, 16'hFFFF);
      settle_block();
      write_register(CSR_UNUSED, {WORD_W{1'b1}});
      send_velocity(AXIS_TURN, 16'hDEAD);
      settle_block();
   endtask

   task automatic test_backpressure();
      load_motors(3'd6);
      rsp_stalls_on = 1'b0;
      req_gaps_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 5; i++)
         send_velocity(2'($urandom_range(0, 2)), random_velocity());
      settle_block();
   endtask

   task automatic test_random_mix();
      logic [2:0] count;
      logic [1:0] axis;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 2) count = 3'd0;
         else if (phase == 5) count = 3'd7;
         else if (phase == 0) count = 3'd6;
         else if (phase == 3) count = 3'd1;
         else count = 3'($urandom_range(1, 6));
         load_motors(count);
         if (phase == 4) write_register(CSR_UNUSED, WORD_W'({$urandom, $urandom}));
         req_gaps_on = (phase % 3) != 0;
         rsp_stalls_on = (phase % 3) != 1;
         for (int n = 0; n < 51; n++) begin
            axis = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            send_velocity(axis, random_velocity());
         end
         settle_block();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_motors();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      test_unity_boundary();
      test_extreme_coefs();
      test_backpressure();
      test_random_mix();
      if (pending_duties.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: thruster_mix_normalizer.f
design/tmn_pkg.sv
design/thruster_mix_normalizer.sv
tb/sv/thruster_mix_normalizer_tb.sv
